@@ hw/rtl/sbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants for the sorted table search block
// Request opcodes, field widths, controller states and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int IdxW   = 10;
  localparam int FieldW = 32;
  localparam int HighW  = 11;
  localparam int BoundW = 12;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic wr;
    logic load;
    logic probe;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic res_free;
  } sts_t;

endpackage

@@ hw/rtl/sbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_ctrl: search sequencer
// Accepts requests, steps the datapath through probe and compare cycles
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module sbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          op_i,
  output logic          in_ready_o,
  input  sbs_pkg::sts_t sts_i,
  output sbs_pkg::cmd_t cmd_o
);
  import sbs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == OP_SEARCH) begin
            cmd_o.load = 1'b1;
            state_d    = ST_PROBE;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (sts_i.empty) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.probe = 1'b1;
          state_d     = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.hit ? ST_FINISH : ST_PROBE;
      end
      ST_FINISH: begin
        if (sts_i.res_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/sbs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_datapath: table memory, search bounds and result register
// Holds the sorted table, the low/high bounds, the key, the probe read
// and the registered result.
// ----------------------------------------------------------------------------
module sbs_datapath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sbs_pkg::cmd_t                    cmd_i,
  output sbs_pkg::sts_t                    sts_o,
  input  logic        [sbs_pkg::IdxW-1:0]   entry_index_i,
  input  logic signed [sbs_pkg::FieldW-1:0] entry_value_i,
  input  logic signed [sbs_pkg::FieldW-1:0] search_key_i,
  input  logic        [sbs_pkg::IdxW-1:0]   range_low_i,
  input  logic signed [sbs_pkg::HighW-1:0]  range_high_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             found_o,
  output logic        [sbs_pkg::IdxW-1:0]   position_o
);
  import sbs_pkg::*;

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int IdxExtW = ((AW > IdxW) ? AW : IdxW) + 1;
  localparam int ExtW    = (VALUE_WIDTH > FieldW) ? VALUE_WIDTH : FieldW;

  logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

  logic signed [BoundW-1:0]      lo_q, hi_q;
  logic signed [VALUE_WIDTH-1:0] key_q;
  logic        [IdxW-1:0]        mid_q;
  logic signed [VALUE_WIDTH-1:0] rdata_q;
  logic                          rin_q;
  logic                          found_q;
  logic                          out_valid_q;
  logic                          res_found_q;
  logic        [IdxW-1:0]        res_pos_q;

  logic signed [ExtW-1:0]        key_ext, val_ext;
  logic signed [BoundW-1:0]      diff, mid_w, mid_ext;
  logic        [IdxW-1:0]        mid;
  logic        [IdxExtW-1:0]     mid_idx, wr_idx;
  logic                          mid_in_range, wr_in_range;
  logic signed [VALUE_WIDTH-1:0] probe_val;
  logic                          hit, greater;

  assign key_ext = ExtW'(search_key_i);
  assign val_ext = ExtW'(entry_value_i);

  assign diff    = hi_q - lo_q;
  assign mid_w   = lo_q + (diff >>> 1);
  assign mid     = mid_w[IdxW-1:0];
  assign mid_ext = {{(BoundW-IdxW){1'b0}}, mid_q};

  assign mid_idx      = IdxExtW'(mid);
  assign wr_idx       = IdxExtW'(entry_index_i);
  assign mid_in_range = mid_idx < IdxExtW'(TABLE_DEPTH);
  assign wr_in_range  = wr_idx < IdxExtW'(TABLE_DEPTH);

  // probes past the table end read zero
  assign probe_val = rin_q ? rdata_q : '0;
  assign hit       = probe_val == key_q;
  assign greater   = probe_val > key_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_in_range) begin
      mem[wr_idx[AW-1:0]] <= val_ext[VALUE_WIDTH-1:0];
    end
    if (cmd_i.probe) begin
      rdata_q <= mem[mid_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lo_q  <= {{(BoundW-IdxW){1'b0}}, range_low_i};
      hi_q  <= {{(BoundW-HighW){range_high_i[HighW-1]}}, range_high_i};
      key_q <= key_ext[VALUE_WIDTH-1:0];
    end else if (cmd_i.step && !hit) begin
      if (greater) begin
        hi_q <= mid_ext - BoundW'(1);
      end else begin
        lo_q <= mid_ext + BoundW'(1);
      end
    end
    if (cmd_i.probe) begin
      mid_q <= mid;
      rin_q <= mid_in_range;
    end
    if (cmd_i.emit) begin
      res_found_q <= found_q;
      res_pos_q   <= found_q ? mid_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.step && hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.empty    = hi_q < lo_q;
  assign sts_o.hit      = hit;
  assign sts_o.res_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign found_o     = res_found_q;
  assign position_o  = res_pos_q;

endmodule

@@ hw/rtl/sorted_table_binary_search.sv @@
`timescale 1ns / 1ps
// Write request: taken while idle, block ready again the next cycle.
// Search request: each probe is a memory read followed by a compare, at most
// ceil(log2(range+1)) probes, 11 over 1024 entries.
// Next request is taken once the result sits in the output register.
// Reset clears control and the output valid; table contents stay undefined.
// ----------------------------------------------------------------------------
// sorted_table_binary_search: binary search over a sorted value table
// Write requests fill the table; search requests return found and position.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic        [sbs_pkg::IdxW-1:0]   entry_index_i,
  input  logic signed [sbs_pkg::FieldW-1:0] entry_value_i,
  input  logic signed [sbs_pkg::FieldW-1:0] search_key_i,
  input  logic        [sbs_pkg::IdxW-1:0]   range_low_i,
  input  logic signed [sbs_pkg::HighW-1:0]  range_high_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             found_o,
  output logic        [sbs_pkg::IdxW-1:0]   position_o
);
  import sbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .found_o       (found_o),
    .position_o    (position_o)
  );

endmodule

@@ hw/rtl/sbs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_checker: port-level checks for the sorted table search block
// Watches the request and result channels; attached by bind.
// ----------------------------------------------------------------------------
module sbs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        op_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        found_o,
  input logic [sbs_pkg::IdxW-1:0]    position_o
);
  import sbs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(found_o) && $stable(position_o))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> position_o == '0)
    else $error("miss with nonzero position");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_SEARCH |=> !in_ready_o)
    else $error("request taken during search");

  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_WRITE |=> in_ready_o)
    else $error("not ready after write");

endmodule

bind sorted_table_binary_search sbs_checker u_sbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .found_o     (found_o),
  .position_o  (position_o)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: request-level check of sorted_table_binary_search
// Drives write and search requests over valid/ready and keeps a shadow copy
// of the value table. Each search is replayed on the shadow copy, probe by
// probe, and the answer is compared with the block's found/position output.
// Searches are issued only when every probe lands on a written entry; entries
// a search would need are written first. Idle and stall rates change by phase.
// ----------------------------------------------------------------------------
module testbench;
  import sbs_pkg::*;

  localparam int Depth     = 1024;
  localparam int HoldLen   = 300;
  localparam int StallMax  = 4000;
  localparam int PhaseLen  = 162;
  localparam int TailWait  = 50;
  localparam logic signed [FieldW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [FieldW-1:0] ValMax = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                     op;
    logic [IdxW-1:0]          idx;
    logic signed [FieldW-1:0] val;
    logic signed [FieldW-1:0] key;
    logic [IdxW-1:0]          lo;
    logic signed [HighW-1:0]  hi;
    bit                       typed;
    bit                       efound;
    logic [IdxW-1:0]          epos;
  } req_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] pos;
  } answer_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_ready;
  logic                     op;
  logic [IdxW-1:0]          entry_index;
  logic signed [FieldW-1:0] entry_value;
  logic signed [FieldW-1:0] search_key;
  logic [IdxW-1:0]          range_low;
  logic signed [HighW-1:0]  range_high;
  logic                     out_valid;
  logic                     out_ready;
  logic                     found;
  logic [IdxW-1:0]          position;

  logic signed [FieldW-1:0] value_mem [Depth];
  bit                       is_written [Depth];
  answer_t                  pending_answers [$];
  req_t                     directed_rows [$];
  int                       mismatches;
  int                       send_pct;
  int                       recv_pct;
  bit                       hold_req;

  sorted_table_binary_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (op),
    .entry_index_i (entry_index),
    .entry_value_i (entry_value),
    .search_key_i  (search_key),
    .range_low_i   (range_low),
    .range_high_i  (range_high),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .found_o       (found),
    .position_o    (position)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Walks the probe sequence; blank is the first unwritten probe, or -1.
  function automatic void predict_lookup(input logic signed [FieldW-1:0] key,
                                         input int lo_in, input int hi_in,
                                         output answer_t ans, output int blank);
    int lo;
    int hi;
    int mid;
    lo = lo_in;
    hi = hi_in;
    ans = '0;
    blank = -1;
    while (hi >= lo && !ans.found) begin
      mid = lo + (hi - lo) / 2;
      if (!is_written[mid] && blank < 0) blank = mid;
      if (value_mem[mid] == key) begin
        ans.found = 1'b1;
        ans.pos = mid[IdxW-1:0];
      end else if (value_mem[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
  endfunction

  function automatic req_t mk_write(input int idx, input logic signed [FieldW-1:0] val);
    req_t r;
    r = '0;
    r.op = OP_WRITE;
    r.idx = idx[IdxW-1:0];
    r.val = val;
    return r;
  endfunction

  function automatic req_t mk_query(input logic signed [FieldW-1:0] key,
                                    input int lo, input int hi);
    req_t r;
    r = '0;
    r.op = OP_SEARCH;
    r.key = key;
    r.lo = lo[IdxW-1:0];
    r.hi = hi[HighW-1:0];
    return r;
  endfunction

  function automatic req_t mk_check(input logic signed [FieldW-1:0] key, input int lo,
                                    input int hi, input bit f, input int pos);
    req_t r;
    r = mk_query(key, lo, hi);
    r.typed = 1'b1;
    r.efound = f;
    r.epos = pos[IdxW-1:0];
    return r;
  endfunction

  // Mostly ascending by index; some duplicates of the left neighbor, some noise.
  function automatic req_t rand_write(input int idx);
    req_t r;
    int sel;
    logic [21:0] low_bits;
    sel = $urandom_range(0, 99);
    low_bits = 22'($urandom);
    r = mk_write(idx, ({idx[IdxW-1:0], low_bits}) ^ 32'h8000_0000);
    if (sel < 8)
      r.val = $urandom;
    else if (sel < 16 && idx > 0 && is_written[idx-1])
      r.val = value_mem[idx-1];
    r.key = $urandom;
    r.lo = IdxW'($urandom);
    r.hi = HighW'($urandom);
    return r;
  endfunction

  function automatic req_t rand_query();
    req_t r;
    int lo;
    int hi;
    int j;
    int sel;
    logic signed [FieldW-1:0] key;
    lo = $urandom_range(0, Depth - 1);
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      hi = $urandom_range(0, lo);
      hi = hi - 1;
    end else if (sel < 15) begin
      lo = 0;
      hi = Depth - 1;
    end else if (sel < 55) begin
      hi = lo + $urandom_range(0, 15);
      if (hi > Depth - 1) hi = Depth - 1;
    end else begin
      hi = $urandom_range(lo, Depth - 1);
    end
    key = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 70 && hi >= lo) begin
      j = $urandom_range(lo, hi);
      if (is_written[j]) key = value_mem[j];
      if (sel >= 50) key = $urandom_range(0, 1) ? key + 1 : key - 1;
    end else if (sel < 80) begin
      case ($urandom_range(0, 3))
        0: key = ValMin;
        1: key = ValMax;
        2: key = 0;
        default: key = -1;
      endcase
    end
    r = mk_query(key, lo, hi);
    r.idx = IdxW'($urandom);
    r.val = $urandom;
    return r;
  endfunction

  task automatic issue(input req_t r);
    answer_t ans;
    int blank;
    while ($urandom_range(0, 99) < send_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid    <= 1'b1;
    op          <= r.op;
    entry_index <= r.idx;
    entry_value <= r.val;
    search_key  <= r.key;
    range_low   <= r.lo;
    range_high  <= r.hi;
    do @(posedge clk_i); while (!in_ready);
    if (r.op == OP_WRITE) begin
      value_mem[r.idx] = r.val;
      is_written[r.idx] = 1'b1;
    end else begin
      predict_lookup(r.key, int'(r.lo), int'(r.hi), ans, blank);
      if (r.typed) begin
        ans.found = r.efound;
        ans.pos = r.epos;
      end
      pending_answers.push_back(ans);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag(input string what, input answer_t e);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch, %s: expected found=%0d position=%0d, got found=%0d position=%0d",
               $realtime, what, e.found, e.pos, found, position);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        flag("unexpected result", '0);
      end else if (found !== pending_answers[0].found ||
                   position !== pending_answers[0].pos) begin
        flag("wrong result", pending_answers.pop_front());
      end else begin
        void'(pending_answers.pop_front());
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldLen) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_pct);
        @(negedge clk_i);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallMax) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    req_t r;
    req_t pend;
    bit have_pend;
    int tries;
    int blank;
    int idx;
    answer_t ans;

    rst_ni = 1'b0;
    in_valid = 1'b0;
    op = OP_WRITE;
    entry_index = '0;
    entry_value = '0;
    search_key = '0;
    range_low = '0;
    range_high = '0;
    mismatches = 0;
    send_pct = 0;
    recv_pct = 0;
    hold_req = 1'b0;
    have_pend = 1'b0;
    tries = 0;
    for (int i = 0; i < Depth; i++) begin
      value_mem[i] = '0;
      is_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty ranges, the table ends, a lone midpoint, unsorted and duplicate runs
    directed_rows.push_back(mk_check(0, 0, -1, 0, 0));
    directed_rows.push_back(mk_check(ValMin, 1023, 1022, 0, 0));
    directed_rows.push_back(mk_check(-1, 1023, -1, 0, 0));
    directed_rows.push_back(mk_write(0, ValMin));
    directed_rows.push_back(mk_write(1023, ValMax));
    directed_rows.push_back(mk_check(ValMin, 0, 0, 1, 0));
    directed_rows.push_back(mk_check(ValMax, 1023, 1023, 1, 1023));
    directed_rows.push_back(mk_check(ValMax, 0, 0, 0, 0));
    directed_rows.push_back(mk_check(ValMin, 1023, 1023, 0, 0));
    directed_rows.push_back(mk_write(511, 0));
    directed_rows.push_back(mk_check(0, 0, 1023, 1, 511));
    directed_rows.push_back(mk_write(512, 2));
    directed_rows.push_back(mk_query(1, 511, 512));
    directed_rows.push_back(mk_query(2, 511, 512));
    directed_rows.push_back(mk_write(1, 100));
    directed_rows.push_back(mk_write(2, -100));
    directed_rows.push_back(mk_query(-100, 0, 2));
    directed_rows.push_back(mk_query(100, 0, 2));
    directed_rows.push_back(mk_write(3, 7));
    directed_rows.push_back(mk_write(4, 7));
    directed_rows.push_back(mk_write(5, 7));
    directed_rows.push_back(mk_query(7, 3, 5));
    foreach (directed_rows[i]) issue(directed_rows[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 51; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 51; end
        default: begin send_pct = 23; recv_pct = 23; end
      endcase
      for (int n = 0; n < PhaseLen; n++) begin
        if (ph == 0 && n == 80) hold_req = 1'b1;
        if (!have_pend) begin
          if ($urandom_range(0, 99) < 25) begin
            idx = $urandom_range(0, Depth - 1);
            if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 1) ? Depth - 1 : 0;
            r = rand_write(idx);
          end else begin
            pend = rand_query();
            have_pend = 1'b1;
            tries = 0;
          end
        end
        if (have_pend) begin
          predict_lookup(pend.key, int'(pend.lo), int'(pend.hi), ans, blank);
          if (blank < 0) begin
            r = pend;
            have_pend = 1'b0;
          end else begin
            r = rand_write(blank);
            tries++;
            if (tries >= 12) have_pend = 1'b0;
          end
        end
        issue(r);
      end
      drain();
    end

    repeat (TailWait) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sbs_pkg.sv
hw/rtl/sbs_ctrl.sv
hw/rtl/sbs_datapath.sv
hw/rtl/sorted_table_binary_search.sv
hw/rtl/sbs_checker.sv
bench/testbench.sv
